### rtl/core/itp_pkg.sv
// Package for the IP/TCP header parser: field widths, family codes, header constants
// and the capture state record shared by the capture stage and the top level.
// No dependencies.
package itp_pkg;

  localparam int POS_W = 16;
  localparam int unsigned MAX_PACKET_BYTES = 65535;

  localparam logic [1:0] FAM_IPV4 = 2'd0;
  localparam logic [1:0] FAM_IPV6 = 2'd1;

  localparam logic [7:0] VER_MASK   = 8'hf0;
  localparam logic [7:0] VER6_CODE  = 8'h60;
  localparam logic [3:0] VER4       = 4'd4;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [5:0] MIN_HDR    = 6'd20;
  localparam logic [5:0] V6_HDR     = 6'd40;

  typedef struct packed {
    logic [POS_W-1:0] byte_position;
    logic [1:0]       family_latched;
    logic [5:0]       ip_header_bytes;
    logic [3:0]       ip_version;
    logic [7:0]       ip_protocol;
    logic [12:0]      fragment_offset;
    logic [3:0]       tcp_data_offset;
    logic [15:0]      source_port;
    logic [15:0]      dest_port;
    logic [31:0]      sequence_number;
    logic [7:0]       flags;
    logic             too_long;
  } hdr_state_t;

  typedef struct packed {
    logic        valid_res;
    logic [5:0]  ip_header_len;
    logic [5:0]  tcp_header_len;
    logic [15:0] payload_len;
    logic [31:0] sequence_number;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  tcp_flag_bits;
  } result_t;

endpackage

### rtl/core/itp_if.sv
// Valid/ready channels of the IP/TCP header parser: byte requests in, results out.
// No dependencies.
interface itp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] family;
  logic       last_byte;

  modport source (output valid, data_byte, family, last_byte, input ready);
  modport sink (input valid, data_byte, family, last_byte, output ready);
endinterface

interface itp_result_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [5:0]  ip_header_len;
  logic [5:0]  tcp_header_len;
  logic [15:0] payload_len;
  logic [31:0] sequence_number;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [7:0]  tcp_flag_bits;

  modport source (output valid, valid_res, ip_header_len, tcp_header_len, payload_len,
                  sequence_number, source_port, dest_port, tcp_flag_bits, input ready);
  modport sink (input valid, valid_res, ip_header_len, tcp_header_len, payload_len,
                sequence_number, source_port, dest_port, tcp_flag_bits, output ready);
endinterface

### rtl/core/ip_tcp_header_parser.sv
// Top level of the IP/TCP header parser: capture stage, header checks and result register.
// Depends on itp_pkg, itp_if (itp_byte_if, itp_result_if) and itp_capture.
//
//  channel  dir  moves                               handshake
//  data     in   data_byte, family, last_byte        valid / ready
//  result   out  valid_res, lengths, seq, ports,     valid / ready
//                flags (one per closing byte)
//
// One byte request is taken every cycle unless stalled; the result register loads
// on the closing byte and shows it in the following cycle.
// Requests are stalled only while a result sits unread and result.ready is low.
// Synchronous reset clears the capture state and the result valid.
module ip_tcp_header_parser (
  input logic          clk,
  input logic          rst,
  itp_byte_if.sink     data,
  itp_result_if.source result
);

  itp_pkg::hdr_state_t snap;
  itp_pkg::result_t    res;
  itp_pkg::result_t    res_next;
  logic                res_valid;
  logic                accept;
  logic                fam_ok;
  logic                ok;
  logic [16:0]         len;
  logic [16:0]         iphl;
  logic [5:0]          thl;
  logic [16:0]         thl_w;

  assign data.ready = !res_valid || result.ready;
  assign accept = data.valid && data.ready;

  itp_capture u_capture (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data.data_byte),
    .family    (data.family),
    .last_byte (data.last_byte),
    .snap      (snap)
  );

  always_comb begin
    len   = {1'b0, snap.byte_position};
    iphl  = 17'(snap.ip_header_bytes);
    thl   = {snap.tcp_data_offset, 2'b00};
    thl_w = 17'(thl);
    case (snap.family_latched)
      itp_pkg::FAM_IPV4: begin
        fam_ok = (len >= 17'(itp_pkg::MIN_HDR)) && (snap.ip_version == itp_pkg::VER4) &&
                 (snap.ip_header_bytes >= itp_pkg::MIN_HDR) && (iphl <= len) &&
                 (snap.fragment_offset == '0) && (snap.ip_protocol == itp_pkg::PROTO_TCP);
      end
      itp_pkg::FAM_IPV6: begin
        fam_ok = (len >= 17'(itp_pkg::V6_HDR)) &&
                 (({snap.ip_version, 4'b0000} & itp_pkg::VER_MASK) == itp_pkg::VER6_CODE) &&
                 (snap.ip_protocol == itp_pkg::PROTO_TCP);
      end
      default: fam_ok = 1'b0;
    endcase
    ok = !snap.too_long && fam_ok && (iphl + 17'(itp_pkg::MIN_HDR) <= len) &&
         (thl >= itp_pkg::MIN_HDR) && (iphl + thl_w <= len);
    res_next = '0;
    if (ok) begin
      res_next.valid_res       = 1'b1;
      res_next.ip_header_len   = snap.ip_header_bytes;
      res_next.tcp_header_len  = thl;
      res_next.payload_len     = 16'(len - iphl - thl_w);
      res_next.sequence_number = snap.sequence_number;
      res_next.source_port     = snap.source_port;
      res_next.dest_port       = snap.dest_port;
      res_next.tcp_flag_bits   = snap.flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && data.last_byte) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && data.last_byte) begin
      res <= res_next;
    end
  end

  assign result.valid           = res_valid;
  assign result.valid_res       = res.valid_res;
  assign result.ip_header_len   = res.ip_header_len;
  assign result.tcp_header_len  = res.tcp_header_len;
  assign result.payload_len     = res.payload_len;
  assign result.sequence_number = res.sequence_number;
  assign result.source_port     = res.source_port;
  assign result.dest_port       = res.dest_port;
  assign result.tcp_flag_bits   = res.tcp_flag_bits;

endmodule

### rtl/core/itp_capture.sv
// Per-byte field capture of the IP/TCP header parser: position counter and header fields.
// Depends on itp_pkg.
module itp_capture (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [7:0]             data_byte,
  input  logic [1:0]             family,
  input  logic                   last_byte,
  output itp_pkg::hdr_state_t    snap
);

  itp_pkg::hdr_state_t hdr;
  itp_pkg::hdr_state_t hdr_next;
  logic [itp_pkg::POS_W-1:0] pos;
  logic [itp_pkg::POS_W-1:0] rel;

  always_comb begin
    hdr_next = hdr;
    pos = hdr.byte_position;
    rel = pos - itp_pkg::POS_W'(hdr_next.ip_header_bytes);
    if (pos >= itp_pkg::POS_W'(itp_pkg::MAX_PACKET_BYTES)) begin
      hdr_next.too_long = 1'b1;
    end else begin
      if (pos == '0) begin
        hdr_next.family_latched = family;
        hdr_next.ip_version = data_byte[7:4];
        case (family)
          itp_pkg::FAM_IPV4: hdr_next.ip_header_bytes = {data_byte[3:0], 2'b00};
          itp_pkg::FAM_IPV6: hdr_next.ip_header_bytes = itp_pkg::V6_HDR;
          default:           hdr_next.ip_header_bytes = '0;
        endcase
      end
      case (hdr_next.family_latched)
        itp_pkg::FAM_IPV4: begin
          if (pos == itp_pkg::POS_W'(6)) begin
            hdr_next.fragment_offset[12:8] = data_byte[4:0];
          end else if (pos == itp_pkg::POS_W'(7)) begin
            hdr_next.fragment_offset[7:0] = data_byte;
          end else if (pos == itp_pkg::POS_W'(9)) begin
            hdr_next.ip_protocol = data_byte;
          end
        end
        itp_pkg::FAM_IPV6: begin
          if (pos == itp_pkg::POS_W'(6)) begin
            hdr_next.ip_protocol = data_byte;
          end
        end
        default: ;
      endcase
      rel = pos - itp_pkg::POS_W'(hdr_next.ip_header_bytes);
      if (pos >= itp_pkg::POS_W'(hdr_next.ip_header_bytes)) begin
        if (rel < itp_pkg::POS_W'(2)) begin
          hdr_next.source_port = {hdr.source_port[7:0], data_byte};
        end else if (rel < itp_pkg::POS_W'(4)) begin
          hdr_next.dest_port = {hdr.dest_port[7:0], data_byte};
        end else if (rel < itp_pkg::POS_W'(8)) begin
          hdr_next.sequence_number = {hdr.sequence_number[23:0], data_byte};
        end else if (rel == itp_pkg::POS_W'(12)) begin
          hdr_next.tcp_data_offset = data_byte[7:4];
        end else if (rel == itp_pkg::POS_W'(13)) begin
          hdr_next.flags = data_byte;
        end
      end
      hdr_next.byte_position = pos + itp_pkg::POS_W'(1);
    end
  end

  // clear after the closing byte so the next datagram starts fresh
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr <= '0;
    end else if (accept) begin
      if (last_byte) begin
        hdr <= '0;
      end else begin
        hdr <= hdr_next;
      end
    end
  end

  assign snap = hdr_next;

endmodule

### rtl/core/itp_checker.sv
// Port-level checks for the IP/TCP header parser, bound to ip_tcp_header_parser.
// Depends on ip_tcp_header_parser and its channel interfaces.
module itp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic        valid_res,
  input logic [5:0]  ip_header_len,
  input logic [5:0]  tcp_header_len,
  input logic [15:0] payload_len,
  input logic [31:0] sequence_number,
  input logic [15:0] source_port,
  input logic [15:0] dest_port,
  input logic [7:0]  tcp_flag_bits
);

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(valid_res) && $stable(payload_len) &&
      $stable(sequence_number))
    else $error("result changed while stalled");

  a_rose_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last))
    else $error("result appeared without a closing byte");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("byte request taken while result is stalled");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> ip_header_len == '0 && tcp_header_len == '0 &&
      payload_len == '0 && sequence_number == '0 && source_port == '0 &&
      dest_port == '0 && tcp_flag_bits == '0)
    else $error("rejected result carries nonzero fields");

  a_valid_lengths: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> ip_header_len >= 6'd20 && tcp_header_len >= 6'd20 &&
      tcp_header_len[1:0] == 2'b00 && ip_header_len[1:0] == 2'b00)
    else $error("accepted result has bad header lengths");

endmodule

bind ip_tcp_header_parser itp_checker u_itp_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (data.valid),
  .in_ready        (data.ready),
  .in_last         (data.last_byte),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .valid_res       (result.valid_res),
  .ip_header_len   (result.ip_header_len),
  .tcp_header_len  (result.tcp_header_len),
  .payload_len     (result.payload_len),
  .sequence_number (result.sequence_number),
  .source_port     (result.source_port),
  .dest_port       (result.dest_port),
  .tcp_flag_bits   (result.tcp_flag_bits)
);

### dv/ip_tcp_header_parser_chk.sv
`timescale 1ns / 100ps
// Checker for the IP/TCP header parser: watches the byte and result channels,
// parses each accepted byte request itself and compares every result field.
// Depends on itp_pkg and itp_if (itp_byte_if, itp_result_if).
module ip_tcp_header_parser_chk (
  input  logic  clk,
  input  logic  rst,
  itp_byte_if   data,
  itp_result_if result,
  output int    fails,
  output int    pending
);

  logic [15:0]      pos;
  logic [1:0]       fam;
  logic [5:0]       iphl;
  logic [3:0]       ver;
  logic [7:0]       proto;
  logic [12:0]      frag;
  logic [3:0]       doff;
  logic [15:0]      sport;
  logic [15:0]      dport;
  logic [31:0]      seq;
  logic [7:0]       flags;
  logic             overflow;
  itp_pkg::result_t expected_headers[$];

  task automatic clear_parse();
    pos = '0;
    fam = '0;
    iphl = '0;
    ver = '0;
    proto = '0;
    frag = '0;
    doff = '0;
    sport = '0;
    dport = '0;
    seq = '0;
    flags = '0;
    overflow = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic [1:0] f, input logic closing);
    int unsigned      rel;
    int unsigned      len;
    int unsigned      hl;
    int unsigned      thl;
    logic             ok;
    itp_pkg::result_t r;
    if (pos >= itp_pkg::MAX_PACKET_BYTES) begin
      overflow = 1'b1;
    end else begin
      if (pos == 0) begin
        fam = f;
        ver = b[7:4];
        if (f == itp_pkg::FAM_IPV4) iphl = {b[3:0], 2'b00};
        else if (f == itp_pkg::FAM_IPV6) iphl = itp_pkg::V6_HDR;
        else iphl = '0;
      end
      if (fam == itp_pkg::FAM_IPV4) begin
        if (pos == 6) frag = {b[4:0], frag[7:0]};
        else if (pos == 7) frag = {frag[12:8], b};
        else if (pos == 9) proto = b;
      end else if (fam == itp_pkg::FAM_IPV6 && pos == 6) begin
        proto = b;
      end
      if (pos >= iphl) begin
        rel = pos - iphl;
        if (rel < 2) sport = {sport[7:0], b};
        else if (rel < 4) dport = {dport[7:0], b};
        else if (rel < 8) seq = {seq[23:0], b};
        else if (rel == 12) doff = b[7:4];
        else if (rel == 13) flags = b;
      end
      pos = pos + 16'd1;
    end
    if (!closing) return;

    len = pos;
    hl = iphl;
    thl = doff * 4;
    ok = !overflow;
    if (fam == itp_pkg::FAM_IPV4) begin
      ok = ok && len >= itp_pkg::MIN_HDR && ver == itp_pkg::VER4 &&
           hl >= itp_pkg::MIN_HDR && hl <= len && frag == '0 && proto == itp_pkg::PROTO_TCP;
    end else if (fam == itp_pkg::FAM_IPV6) begin
      ok = ok && len >= itp_pkg::V6_HDR &&
           (({ver, 4'h0} & itp_pkg::VER_MASK) == itp_pkg::VER6_CODE) &&
           proto == itp_pkg::PROTO_TCP;
    end else begin
      ok = 1'b0;
    end
    ok = ok && hl + itp_pkg::MIN_HDR <= len && thl >= itp_pkg::MIN_HDR && hl + thl <= len;

    r = '0;
    if (ok) begin
      r.valid_res = 1'b1;
      r.ip_header_len = hl[5:0];
      r.tcp_header_len = thl[5:0];
      r.payload_len = 16'(len - hl - thl);
      r.sequence_number = seq;
      r.source_port = sport;
      r.dest_port = dport;
      r.tcp_flag_bits = flags;
    end
    expected_headers.push_back(r);
    clear_parse();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    itp_pkg::result_t r;
    if (rst) begin
      clear_parse();
      expected_headers.delete();
      fails = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_headers.size() == 0) begin
          $error("result with no datagram outstanding");
          fails++;
        end else begin
          r = expected_headers.pop_front();
          check_field("valid_res", r.valid_res, result.valid_res);
          check_field("ip_header_len", r.ip_header_len, result.ip_header_len);
          check_field("tcp_header_len", r.tcp_header_len, result.tcp_header_len);
          check_field("payload_len", r.payload_len, result.payload_len);
          check_field("sequence_number", r.sequence_number, result.sequence_number);
          check_field("source_port", r.source_port, result.source_port);
          check_field("dest_port", r.dest_port, result.dest_port);
          check_field("tcp_flag_bits", r.tcp_flag_bits, result.tcp_flag_bits);
        end
      end
      if (data.valid && data.ready) begin
        parse_byte(data.data_byte, data.family, data.last_byte);
      end
    end
    pending = expected_headers.size();
  end

endmodule

### dv/ip_tcp_header_parser_tb.sv
`timescale 1ns / 100ps
// Testbench top for the IP/TCP header parser: clock, reset, datagram stimulus
// with random idling on both channels, and the verdict.
// Depends on itp_pkg, itp_if, ip_tcp_header_parser and ip_tcp_header_parser_chk.
module ip_tcp_header_parser_tb;

  localparam logic [1:0] FAM_OTHER  = 2'd2;
  localparam logic [1:0] FAM_UNUSED = 2'd3;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_HOP  = 8'd0;
  localparam int CYCLE_LIMIT        = 2_000_000;
  localparam int RANDOM_PACKETS     = 3;
  localparam int PRESSURE_PACKET    = 1;
  localparam int QUIET_PACKETS      = 1;
  localparam int DRAIN_CYCLES       = 20;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic quiet = 1'b0;
  int   fails;
  int   pending;
  int   cycle_count;
  int   rx_hold = 0;
  int   rx_calm = 0;
  fill_t fill_mode = FILL_RANDOM;
  logic [7:0] pkt[$];

  itp_byte_if   data_ch ();
  itp_result_if result_ch ();

  always #5 clk = ~clk;

  ip_tcp_header_parser dut (
    .clk    (clk),
    .rst    (rst),
    .data   (data_ch),
    .result (result_ch)
  );

  ip_tcp_header_parser_chk hdr_chk (
    .clk     (clk),
    .rst     (rst),
    .data    (data_ch),
    .result  (result_ch),
    .fails   (fails),
    .pending (pending)
  );

  function automatic logic [7:0] fill_byte();
    case (fill_mode)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hff;
      default:   return 8'($urandom_range(255, 0));
    endcase
  endfunction

  task automatic send_datagram(input logic [1:0] fam, input logic [3:0] ver,
                               input logic [3:0] ihl, input logic [7:0] proto,
                               input logic [12:0] frag, input logic [3:0] doff,
                               input int payload, input int keep, input bit calm);
    int hdr;
    int tcp;
    pkt.delete();
    hdr = (fam == itp_pkg::FAM_IPV4) ? ((ihl < 5) ? 20 : ihl * 4) : 40;
    for (int i = 0; i < hdr; i++) pkt.push_back(fill_byte());
    pkt[0] = {ver, (fam == itp_pkg::FAM_IPV4) ? ihl : pkt[0][3:0]};
    if (fam == itp_pkg::FAM_IPV4) begin
      pkt[6] = {pkt[6][7:5], frag[12:8]};
      pkt[7] = frag[7:0];
      pkt[9] = proto;
    end else begin
      pkt[6] = proto;
    end
    tcp = (doff < 5) ? 20 : doff * 4;
    for (int i = 0; i < tcp; i++) pkt.push_back(fill_byte());
    pkt[hdr + 12] = {doff, pkt[hdr + 12][3:0]};
    for (int i = 0; i < payload; i++) pkt.push_back(fill_byte());
    // truncate for short datagrams
    while (keep > 0 && pkt.size() > keep) void'(pkt.pop_back());

    foreach (pkt[i]) begin
      if (!quiet && !calm && $urandom_range(9, 0) == 0) begin
        data_ch.valid <= 1'b0;
        repeat ($urandom_range(7, 1)) @(negedge clk);
      end
      data_ch.valid <= 1'b1;
      data_ch.data_byte <= pkt[i];
      data_ch.family <= (i == 0) ? fam : 2'($urandom_range(3, 0));
      data_ch.last_byte <= (i == pkt.size() - 1);
      @(posedge clk);
      while (!data_ch.ready) @(posedge clk);
      @(negedge clk);
    end
  endtask

  task automatic send_random_datagram(input bit well_formed);
    logic [1:0]  fam;
    logic [3:0]  ver;
    logic [7:0]  proto;
    logic [12:0] frag;
    int          keep;
    if (well_formed) begin
      fam = 2'($urandom_range(1, 0));
      ver = (fam == itp_pkg::FAM_IPV4) ? itp_pkg::VER4 : itp_pkg::VER6_CODE[7:4];
      send_datagram(fam, ver, 4'($urandom_range(15, 5)), itp_pkg::PROTO_TCP, '0,
                    4'($urandom_range(15, 5)),
                    ($urandom_range(3, 0) == 0) ? $urandom_range(60, 0)
                                                : $urandom_range(12, 0),
                    -1, $urandom_range(3, 0) == 0);
    end else begin
      fam = 2'($urandom_range(3, 0));
      ver = $urandom_range(1, 0) ? 4'($urandom_range(15, 0))
                                 : ((fam == itp_pkg::FAM_IPV4) ? itp_pkg::VER4
                                                               : itp_pkg::VER6_CODE[7:4]);
      proto = $urandom_range(1, 0) ? itp_pkg::PROTO_TCP : 8'($urandom_range(255, 0));
      frag = $urandom_range(1, 0) ? 13'd0 : 13'($urandom_range(8191, 0));
      keep = $urandom_range(1, 0) ? -1 : $urandom_range(80, 1);
      send_datagram(fam, ver, 4'($urandom_range(15, 0)), proto, frag,
                    4'($urandom_range(15, 0)), $urandom_range(16, 0), keep,
                    $urandom_range(3, 0) == 0);
    end
  endtask

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet || rx_calm > 0) begin
        result_ch.ready <= 1'b1;
        if (rx_calm > 0) rx_calm--;
      end else if (rx_hold > 0) begin
        result_ch.ready <= 1'b0;
        rx_hold--;
        if (rx_hold == 0 && $urandom_range(3, 0) == 0) rx_calm = $urandom_range(200, 20);
      end else if ($urandom_range(7, 0) == 0) begin
        result_ch.ready <= 1'b0;
        rx_hold = $urandom_range(6, 0);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[ip_tcp_header_parser] ERROR");
    $finish;
  end

  initial begin
    int pkts;
    data_ch.valid = 1'b0;
    data_ch.data_byte = '0;
    data_ch.family = '0;
    data_ch.last_byte = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    fill_mode = FILL_ZERO;
    send_datagram(itp_pkg::FAM_IPV4, itp_pkg::VER4, 4'd5, itp_pkg::PROTO_TCP, '0, 4'd5, 0,
                  -1, 1'b0);
    fill_mode = FILL_ONES;
    send_datagram(itp_pkg::FAM_IPV4, itp_pkg::VER4, 4'd15, itp_pkg::PROTO_TCP, '0, 4'd15, 10,
                  -1, 1'b0);
    fill_mode = FILL_RANDOM;
    send_datagram(itp_pkg::FAM_IPV6, 4'd6, 4'd0, itp_pkg::PROTO_TCP, '0, 4'd5, 3, -1, 1'b0);
    send_datagram(itp_pkg::FAM_IPV6, 4'd6, 4'd0, itp_pkg::PROTO_TCP, '0, 4'd15, 0, -1, 1'b0);
    send_datagram(FAM_OTHER, itp_pkg::VER4, 4'd5, itp_pkg::PROTO_TCP, '0, 4'd5, 8, -1, 1'b0);
    send_datagram(FAM_UNUSED, 4'd6, 4'd0, itp_pkg::PROTO_TCP, '0, 4'd5, 8, -1, 1'b0);
    send_datagram(itp_pkg::FAM_IPV4, 4'd6, 4'd5, itp_pkg::PROTO_TCP, '0, 4'd5, 4, -1, 1'b0);
    send_datagram(itp_pkg::FAM_IPV6, itp_pkg::VER4, 4'd0, itp_pkg::PROTO_TCP, '0, 4'd5, 4,
                  -1, 1'b0);
    send_datagram(itp_pkg::FAM_IPV4, itp_pkg::VER4, 4'd5, PROTO_UDP, '0, 4'd5, 4, -1, 1'b0);
    send_datagram(itp_pkg::FAM_IPV6, 4'd6, 4'd0, PROTO_HOP, '0, 4'd5, 4, -1, 1'b0);
    send_datagram(itp_pkg::FAM_IPV4, itp_pkg::VER4, 4'd5, itp_pkg::PROTO_TCP, 13'h1fff, 4'd5,
                  4, -1, 1'b0);
    send_datagram(itp_pkg::FAM_IPV4, itp_pkg::VER4, 4'd5, itp_pkg::PROTO_TCP, 13'h0001, 4'd5,
                  4, -1, 1'b0);
    send_datagram(itp_pkg::FAM_IPV4, itp_pkg::VER4, 4'd0, itp_pkg::PROTO_TCP, '0, 4'd5, 4,
                  -1, 1'b0);
    send_datagram(itp_pkg::FAM_IPV4, itp_pkg::VER4, 4'd4, itp_pkg::PROTO_TCP, '0, 4'd5, 4,
                  -1, 1'b0);
    send_datagram(itp_pkg::FAM_IPV4, itp_pkg::VER4, 4'd5, itp_pkg::PROTO_TCP, '0, 4'd4, 4,
                  -1, 1'b0);
    send_datagram(itp_pkg::FAM_IPV4, itp_pkg::VER4, 4'd5, itp_pkg::PROTO_TCP, '0, 4'd0, 4,
                  -1, 1'b0);
    send_datagram(itp_pkg::FAM_IPV4, itp_pkg::VER4, 4'd5, itp_pkg::PROTO_TCP, '0, 4'd5, 0,
                  19, 1'b0);
    send_datagram(itp_pkg::FAM_IPV4, itp_pkg::VER4, 4'd5, itp_pkg::PROTO_TCP, '0, 4'd5, 0,
                  30, 1'b0);
    send_datagram(itp_pkg::FAM_IPV6, 4'd6, 4'd0, itp_pkg::PROTO_TCP, '0, 4'd5, 0, 39, 1'b0);
    send_datagram(itp_pkg::FAM_IPV4, itp_pkg::VER4, 4'd5, itp_pkg::PROTO_TCP, '0, 4'd5, 0,
                  1, 1'b0);
    send_datagram(itp_pkg::FAM_IPV4, itp_pkg::VER4, 4'd5, itp_pkg::PROTO_TCP, '0, 4'd15, 0,
                  59, 1'b0);
    send_datagram(itp_pkg::FAM_IPV6, 4'd6, 4'd0, itp_pkg::PROTO_TCP, '0, 4'd5, 0, 59, 1'b0);

    for (pkts = 0; pkts < RANDOM_PACKETS; pkts++) begin
      // hold off until every result is drained
      if (pkts == PRESSURE_PACKET) begin
        data_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      send_random_datagram($urandom_range(4, 0) != 0);
    end

    quiet = 1'b1;
    repeat (QUIET_PACKETS) send_random_datagram(1'b1);

    data_ch.valid <= 1'b0;
    data_ch.last_byte <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fails == 0) begin
      $display("[ip_tcp_header_parser] OK");
    end else begin
      $display("[ip_tcp_header_parser] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/itp_pkg.sv
rtl/core/itp_if.sv
rtl/core/itp_capture.sv
rtl/core/ip_tcp_header_parser.sv
rtl/core/itp_checker.sv
dv/ip_tcp_header_parser_chk.sv
dv/ip_tcp_header_parser_tb.sv
